// ===== sv/dbla_pkg.sv =====
// Shared types and constants of the disk busy load average block.
package dbla_pkg;

  localparam int unsigned NumDevices = 32;
  localparam int unsigned DevW       = 5;
  localparam int unsigned StoreDepth = (NumDevices < 32) ? NumDevices : 32;
  localparam int unsigned DevAw      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned CntW       = 48;
  localparam int unsigned AvgW       = 24;
  localparam int unsigned IvW        = 32;
  localparam int unsigned DecW       = 16;
  localparam int unsigned QuoW       = 25;
  localparam int unsigned CfgW       = 32;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgInterval    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDecayShort  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDecayMedium = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDecayLong   = 2'd3;

  localparam logic [IvW-1:0]  IntervalRst    = 32'd5000000;
  localparam logic [DecW-1:0] DecayShortRst  = 16'd60296;
  localparam logic [DecW-1:0] DecayMediumRst = 16'd64453;
  localparam logic [DecW-1:0] DecayLongRst   = 16'd65172;

  localparam logic [AvgW-1:0] PctMax = 24'hFF0000;

  typedef struct packed {
    logic            in_range;
    logic            restart;
    logic [DevW-1:0] device;
    logic [CntW-1:0] counter;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fe_out_t;

  typedef struct packed {
    logic [IvW-1:0]  interval;
    logic [DecW-1:0] decay_short;
    logic [DecW-1:0] decay_medium;
    logic [DecW-1:0] decay_long;
  } cfg_t;

  typedef struct packed {
    logic [DevW-1:0] device;
    logic [AvgW-1:0] avg_short;
    logic [AvgW-1:0] avg_medium;
    logic [AvgW-1:0] avg_long;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0] prev;
    logic [AvgW-1:0] avg_short;
    logic [AvgW-1:0] avg_medium;
    logic [AvgW-1:0] avg_long;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== sv/disk_busy_load_average.sv =====
// Top level: per-device 1/5/15 minute busy-percent averages from busy counters.
// A normal sample runs state read, classify, the 25-step serial divider, saturate,
//   then three EMA updates on the shared 24x17 multiplier and write-back; a
//   saturated one skips both. The back end holds one sample at a time. Restarts and
//   out-of-range ones get a zero result, one a cycle if the result queue has room.
// Reset: all averages and previous counters read as zero (per-entry valid
//   bits); config registers return to their defaults; both queues empty.
module disk_busy_load_average import dbla_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample input queue
  input  logic               push,
  output logic               full,
  input  logic [DevW-1:0]    device_i,
  input  logic [CntW-1:0]    busy_counter_us_i,
  input  logic               restart_i,
  // result queue
  output logic               empty,
  input  logic               pop,
  output logic [DevW-1:0]    out_device_o,
  output logic [AvgW-1:0]    avg_short_o,
  output logic [AvgW-1:0]    avg_medium_o,
  output logic [AvgW-1:0]    avg_long_o,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t    cfg_q, cfg_d;
  fe_out_t fe;
  logic    bk_pop;
  result_t res;

  // Config registers; the user writes them only while idle; the block does not check.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInterval:    cfg_d.interval     = cfg_wdata_i;
        CfgDecayShort:  cfg_d.decay_short  = cfg_wdata_i[DecW-1:0];
        CfgDecayMedium: cfg_d.decay_medium = cfg_wdata_i[DecW-1:0];
        CfgDecayLong:   cfg_d.decay_long   = cfg_wdata_i[DecW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval     <= IntervalRst;
      cfg_q.decay_short  <= DecayShortRst;
      cfg_q.decay_medium <= DecayMediumRst;
      cfg_q.decay_long   <= DecayLongRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: takes beats, tags range/restart, two-entry queue toward the back.
  dbla_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .device_i          (device_i),
    .busy_counter_us_i (busy_counter_us_i),
    .restart_i         (restart_i),
    .fe_o              (fe),
    .pop_i             (bk_pop)
  );

  // Back: state RAM read, diff, divide or saturate to percent, three EMA updates,
  // write-back and a two-entry result queue.
  dbla_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .fe_i    (fe),
    .pop_o   (bk_pop),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res)
  );

  assign out_device_o = res.device;
  assign avg_short_o  = res.avg_short;
  assign avg_medium_o = res.avg_medium;
  assign avg_long_o   = res.avg_long;

  // Back end only dequeues an item the front actually holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bk_pop |-> fe.valid)
    else $error("back end popped an empty front queue");

  // An accepted beat is visible to the back end on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push && !full) |=> fe.valid)
    else $error("accepted sample lost in front queue");

  // A waiting result is never dropped without a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (!empty && !pop) |=> !empty)
    else $error("pending result vanished");

endmodule

// ===== sv/dbla_ram.sv =====
// Generic single-port RAM with registered read.
module dbla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                       wdata_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dbla_front.sv =====
// Front end: accepts samples, classifies them and queues them for the back end.
module dbla_front import dbla_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [DevW-1:0]     device_i,
  input  logic [CntW-1:0]     busy_counter_us_i,
  input  logic                restart_i,
  output fe_out_t             fe_o,
  input  logic                pop_i
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, take;
  item_t      item_in;

  assign full_o = (cnt_q == 2'd2);
  assign accept = push_i & ~full_o;
  assign take   = pop_i & (cnt_q != 2'd0);

  always_comb begin
    item_in.in_range = (32'(device_i) < NumDevices);
    item_in.restart  = restart_i;
    item_in.device   = device_i;
    item_in.counter  = busy_counter_us_i;
  end

  always_comb begin
    wr_ptr_d = accept ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    case ({accept, take})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  assign fe_o.valid = (cnt_q != 2'd0);
  assign fe_o.item  = slot_q[rd_ptr_q];

endmodule

// ===== sv/dbla_back.sv =====
// Back end: per-device state, serial divider, shared multiplier, result queue.
module dbla_back import dbla_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  fe_out_t fe_i,
  output logic    pop_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t res_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SClass = 3'd2;
  localparam logic [2:0] SDiv   = 3'd3;
  localparam logic [2:0] SSat   = 3'd4;
  localparam logic [2:0] SMul   = 3'd5;
  localparam logic [2:0] SAcc   = 3'd6;
  localparam logic [2:0] SWrite = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [StoreDepth-1:0] valid_q, valid_d;
  item_t                 item_q, item_d;
  logic [CntW-1:0]       diff_q, diff_d;
  logic [AvgW-1:0]       avg_q [3];
  logic [AvgW-1:0]       avg_d [3];
  logic [AvgW-1:0]       new_q [3];
  logic [AvgW-1:0]       new_d [3];
  logic [IvW-1:0]        rem_q, rem_d;
  logic [QuoW-1:0]       num_q, num_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [AvgW-1:0]       pct_q, pct_d;
  logic [41:0]           acc_q, acc_d;
  logic [40:0]           prod_q, prod_d;
  logic [1:0]            k_q, k_d;
  logic                  ph_q, ph_d;

  // result queue
  result_t    oq_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q, ocnt_d;
  logic       opush, opop;
  result_t    opush_data;

  // state RAM
  logic             ram_we;
  logic [DevAw-1:0] ram_addr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  entry_t           rd_entry;

  logic [IvW-1:0]   iv;
  logic [33:0]      iv3;
  logic [DevAw-1:0] item_addr;
  logic [DevAw-1:0] fe_addr;
  logic [33:0]      d34;
  logic [40:0]      d100;
  logic [56:0]      dividend;
  logic [32:0]      trial;
  logic             ge;
  logic [DecW-1:0]  dsel;
  logic [AvgW-1:0]  mul_a;
  logic [16:0]      mul_b;
  logic [41:0]      sum;
  logic [24:0]      rnd;
  logic [AvgW-1:0]  ema;

  dbla_ram #(
    .Width (EntryW),
    .Depth (StoreDepth)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign iv        = (cfg_i.interval == '0) ? IvW'(1) : cfg_i.interval;
  assign iv3       = {2'b00, iv} + {1'b0, iv, 1'b0};
  assign item_addr = DevAw'(item_q.device);
  assign fe_addr   = DevAw'(fe_i.item.device);
  // never-written entries read as zero
  assign rd_entry  = valid_q[item_addr] ? ram_rdata : '0;

  // diff * 100 * 65536 built from shifts and adds
  assign d34      = diff_q[33:0];
  assign d100     = 41'({d34, 6'b0}) + 41'({d34, 5'b0}) + 41'({d34, 2'b0});
  assign dividend = {d100, 16'b0};

  assign trial = {rem_q, num_q[QuoW-1]};
  assign ge    = (trial >= {1'b0, iv});

  always_comb begin
    case (k_q)
      2'd0:    dsel = cfg_i.decay_short;
      2'd1:    dsel = cfg_i.decay_medium;
      default: dsel = cfg_i.decay_long;
    endcase
  end

  always_comb begin
    if (!ph_q) begin
      mul_a = avg_q[k_q];
      mul_b = {1'b0, dsel};
    end else begin
      mul_a = pct_q;
      mul_b = 17'h10000 - {1'b0, dsel};
    end
  end

  assign sum = acc_q + {1'b0, prod_q};
  assign rnd = sum[40:16];
  assign ema = (rnd > {1'b0, PctMax}) ? PctMax : rnd[AvgW-1:0];

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    item_d     = item_q;
    diff_d     = diff_q;
    avg_d      = avg_q;
    new_d      = new_q;
    rem_d      = rem_q;
    num_d      = num_q;
    cnt_d      = cnt_q;
    pct_d      = pct_q;
    acc_d      = acc_q;
    prod_d     = prod_q;
    k_d        = k_q;
    ph_d       = ph_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = item_addr;
    ram_wdata  = '0;
    opush      = 1'b0;
    opush_data = '0;

    case (state_q)
      SIdle: begin
        ram_addr = fe_addr;
        if (fe_i.valid && (ocnt_q != 2'd2)) begin
          pop_o             = 1'b1;
          item_d            = fe_i.item;
          opush_data.device = fe_i.item.device;
          if (!fe_i.item.in_range) begin
            opush = 1'b1;
          end else if (fe_i.item.restart) begin
            ram_we            = 1'b1;
            ram_wdata.prev    = fe_i.item.counter;
            valid_d[fe_addr]  = 1'b1;
            opush             = 1'b1;
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        avg_d[0] = rd_entry.avg_short;
        avg_d[1] = rd_entry.avg_medium;
        avg_d[2] = rd_entry.avg_long;
        // a counter that went backwards counts as no busy time
        diff_d   = (item_q.counter >= rd_entry.prev) ? item_q.counter - rd_entry.prev : '0;
        state_d  = SClass;
      end
      SClass: begin
        if (diff_q >= {14'b0, iv3}) begin
          pct_d   = PctMax;
          acc_d   = 42'd32768;
          k_d     = 2'd0;
          ph_d    = 1'b0;
          state_d = SMul;
        end else begin
          rem_d   = dividend[56:QuoW];
          num_d   = dividend[QuoW-1:0];
          cnt_d   = 5'd0;
          state_d = SDiv;
        end
      end
      SDiv: begin
        rem_d = ge ? IvW'(trial - {1'b0, iv}) : trial[IvW-1:0];
        num_d = {num_q[QuoW-2:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(QuoW - 1)) begin
          state_d = SSat;
        end
      end
      SSat: begin
        pct_d   = (num_q > {1'b0, PctMax}) ? PctMax : num_q[AvgW-1:0];
        acc_d   = 42'd32768;
        k_d     = 2'd0;
        ph_d    = 1'b0;
        state_d = SMul;
      end
      SMul: begin
        prod_d  = 41'(mul_a) * 41'(mul_b);
        state_d = SAcc;
      end
      SAcc: begin
        if (!ph_q) begin
          acc_d   = sum;
          ph_d    = 1'b1;
          state_d = SMul;
        end else begin
          new_d[k_q] = ema;
          acc_d      = 42'd32768;
          ph_d       = 1'b0;
          if (k_q == 2'd2) begin
            state_d = SWrite;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = SMul;
          end
        end
      end
      SWrite: begin
        ram_we               = 1'b1;
        ram_wdata.prev       = item_q.counter;
        ram_wdata.avg_short  = new_q[0];
        ram_wdata.avg_medium = new_q[1];
        ram_wdata.avg_long   = new_q[2];
        valid_d[item_addr]   = 1'b1;
        opush                = 1'b1;
        opush_data.device     = item_q.device;
        opush_data.avg_short  = new_q[0];
        opush_data.avg_medium = new_q[1];
        opush_data.avg_long   = new_q[2];
        state_d              = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign empty_o = (ocnt_q == 2'd0);
  assign opop    = pop_i & ~empty_o;
  assign res_o   = oq_q[ord_q];

  always_comb begin
    case ({opush, opop})
      2'b10:   ocnt_d = ocnt_q + 2'd1;
      2'b01:   ocnt_d = ocnt_q - 2'd1;
      default: ocnt_d = ocnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      valid_q <= '0;
      k_q     <= 2'd0;
      ph_q    <= 1'b0;
      cnt_q   <= 5'd0;
      owr_q   <= 1'b0;
      ord_q   <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      k_q     <= k_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      owr_q   <= opush ? ~owr_q : owr_q;
      ord_q   <= opop ? ~ord_q : ord_q;
      ocnt_q  <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    diff_q <= diff_d;
    avg_q  <= avg_d;
    new_q  <= new_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    pct_q  <= pct_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    if (opush) begin
      oq_q[owr_q] <= opush_data;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench for disk_busy_load_average: directed and random samples checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import dbla_pkg::*;

  // Cycles with no beat on either side before the run is declared hung.
  // This leaves a wide margin over a normal sample with the random stalls on top.
  localparam int unsigned StallLimit = 2000;
  // Settle time after the last result, longer than one normal sample takes.
  localparam int unsigned TailCycles = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [DevW-1:0]    device_i = '0;
  logic [CntW-1:0]    busy_counter_us_i = '0;
  logic               restart_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [DevW-1:0]    out_device_o;
  logic [AvgW-1:0]    avg_short_o;
  logic [AvgW-1:0]    avg_medium_o;
  logic [AvgW-1:0]    avg_long_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  disk_busy_load_average dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .device_i          (device_i),
    .busy_counter_us_i (busy_counter_us_i),
    .restart_i         (restart_i),
    .empty             (empty),
    .pop               (pop),
    .out_device_o      (out_device_o),
    .avg_short_o       (avg_short_o),
    .avg_medium_o      (avg_medium_o),
    .avg_long_o        (avg_long_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the per-device store and of the config
  // registers, both at their reset values.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] last_busy  [NumDevices] = '{default: '0};
  logic [AvgW-1:0] load_short [NumDevices] = '{default: '0};
  logic [AvgW-1:0] load_medium[NumDevices] = '{default: '0};
  logic [AvgW-1:0] load_long  [NumDevices] = '{default: '0};

  logic [IvW-1:0]  cfg_interval     = IntervalRst;
  logic [DecW-1:0] cfg_decay_short  = DecayShortRst;
  logic [DecW-1:0] cfg_decay_medium = DecayMediumRst;
  logic [DecW-1:0] cfg_decay_long   = DecayLongRst;

  // Averages still owed by the block, oldest first.
  result_t pending_averages[$];

  int unsigned send_gap_pct  = 0;  // chance per cycle that the sender holds off
  int unsigned pop_stall_pct = 0;  // chance per cycle that the receiver stalls
  int unsigned bad_beats     = 0;
  int unsigned idle_cycles   = 0;

  // One EMA step: avg*d + pct*(1-d) in Q0.16, round half up, clamp at 255.0.
  function automatic logic [AvgW-1:0] ema_step(logic [AvgW-1:0] avg, logic [AvgW-1:0] pct,
                                               logic [DecW-1:0] d);
    logic [63:0] acc;
    acc = 64'(avg) * 64'(d) + 64'(pct) * (64'd65536 - 64'(d)) + 64'd32768;
    acc = acc >> 16;
    if (acc > 64'(PctMax)) acc = 64'(PctMax);
    return acc[AvgW-1:0];
  endfunction

  // Busy percent from the counter delta, then the three averages of the device.
  function automatic result_t predict_load_average(logic [DevW-1:0] dev, logic [CntW-1:0] cnt,
                                                   logic rs);
    result_t     res;
    logic [63:0] iv;
    logic [63:0] diff;
    logic [63:0] pct;
    res = '0;
    res.device = dev;
    if (rs) begin
      // newly seen device: take its counter as the base, forget its history
      last_busy[dev]   = cnt;
      load_short[dev]  = '0;
      load_medium[dev] = '0;
      load_long[dev]   = '0;
      return res;
    end
    iv = (cfg_interval == '0) ? 64'd1 : 64'(cfg_interval);
    // counter going backwards counts as no busy time
    diff = (cnt >= last_busy[dev]) ? 64'(cnt - last_busy[dev]) : 64'd0;
    if (diff >= 3 * iv) begin
      pct = 64'(PctMax);
    end else begin
      pct = diff * 64'd6553600 / iv;
      if (pct > 64'(PctMax)) pct = 64'(PctMax);
    end
    load_short[dev]  = ema_step(load_short[dev],  pct[AvgW-1:0], cfg_decay_short);
    load_medium[dev] = ema_step(load_medium[dev], pct[AvgW-1:0], cfg_decay_medium);
    load_long[dev]   = ema_step(load_long[dev],   pct[AvgW-1:0], cfg_decay_long);
    last_busy[dev]   = cnt;
    res.avg_short  = load_short[dev];
    res.avg_medium = load_medium[dev];
    res.avg_long   = load_long[dev];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. push stays high across back-to-back beats; it drops only when
  // the sender decides to idle or stops to wait for the owed results.
  // ---------------------------------------------------------------------------
  task automatic send_sample(logic [DevW-1:0] dev, logic [CntW-1:0] cnt, logic rs);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push              <= 1'b1;
    device_i          <= dev;
    busy_counter_us_i <= cnt;
    restart_i         <= rs;
    do @(posedge clk_i); while (full);
    pending_averages.push_back(predict_load_average(dev, cnt, rs));
  endtask

  // Stop sending and wait until every owed result has been popped.
  task automatic wait_all_results();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_averages.size() != 0);
  endtask

  // Register write; only called while the block is drained.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgInterval:    cfg_interval     = data;
      CfgDecayShort:  cfg_decay_short  = data[DecW-1:0];
      CfgDecayMedium: cfg_decay_medium = data[DecW-1:0];
      CfgDecayLong:   cfg_decay_long   = data[DecW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [IvW-1:0] iv, logic [DecW-1:0] ds, logic [DecW-1:0] dm,
                             logic [DecW-1:0] dl);
    wait_all_results();
    write_reg(CfgInterval,    CfgW'(iv));
    write_reg(CfgDecayShort,  CfgW'(ds));
    write_reg(CfgDecayMedium, CfgW'(dm));
    write_reg(CfgDecayLong,   CfgW'(dl));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: check each popped beat against the oldest expectation,
  // then roll the pop for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.device     = out_device_o;
        got.avg_short  = avg_short_o;
        got.avg_medium = avg_medium_o;
        got.avg_long   = avg_long_o;
        if (pending_averages.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected result beat: dev %0d short %h medium %h long %h",
                     got.device, got.avg_short, got.avg_medium, got.avg_long);
        end else begin
          want = pending_averages.pop_front();
          if (got.device !== want.device || got.avg_short !== want.avg_short ||
              got.avg_medium !== want.avg_medium || got.avg_long !== want.avg_long) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("result beat differs: dev exp %0d got %0d, short exp %h got %h,",
                       want.device, got.device, want.avg_short, got.avg_short,
                       " medium exp %h got %h, long exp %h got %h",
                       want.avg_medium, got.avg_medium, want.avg_long, got.avg_long);
          end
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Hang detector: any beat on either side resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
        $display("disk_busy_load_average: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default config (5 s interval): zero delta, counter extremes, saturation,
  // counter going backwards, restart, and the edge around three intervals.
  task automatic test_directed_samples();
    send_gap_pct  = 26;
    pop_stall_pct = 56;
    send_sample(5'd0,  48'd0, 1'b0);                    // nothing happened since reset
    send_sample(5'd31, 48'hFFFF_FFFF_FFFF, 1'b0);       // huge delta saturates
    send_sample(5'd31, 48'hFFFF_FFFF_FFFF, 1'b0);       // zero delta, averages decay
    send_sample(5'd31, 48'd0, 1'b0);                    // backwards -> zero busy
    send_sample(5'd3,  48'h8000_0000_0000, 1'b1);       // restart
    send_sample(5'd3,  48'h8000_0026_25A0, 1'b0);       // +2.5 s -> 50 %
    send_sample(5'd3,  48'h8000_0026_25A0 + 48'd14999999, 1'b0); // just under 3x
    send_sample(5'd3,  48'h8000_0026_25A0 + 48'd29999999, 1'b0); // exactly 3x
    send_sample(5'd3,  48'h8000_0026_25A0 + 48'd34999999, 1'b0); // 100 %
    send_sample(5'd3,  48'd5, 1'b1);                    // restart again, low base
    send_sample(5'd3,  48'd4, 1'b0);                    // backwards right after restart
    send_sample(5'd17, 48'd1, 1'b0);                    // single microsecond
  endtask

  // Register extremes: zero interval acts as one, decay 0 / max, widest interval.
  task automatic test_config_extremes();
    load_config(32'd0, 16'h0000, 16'hFFFF, 16'h8000);
    send_sample(5'd9, 48'd100, 1'b1);
    send_sample(5'd9, 48'd100, 1'b0);                   // zero delta
    send_sample(5'd9, 48'd101, 1'b0);                   // 1 us of 1 us -> 100 %
    send_sample(5'd9, 48'd104, 1'b0);                   // 3x the interval
    load_config(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'h0001);
    send_sample(5'd9, 48'd104 + 48'h2_FFFF_FFFC, 1'b0); // 3x - 1 of the widest interval
    send_sample(5'd9, 48'd104 + 48'h3_FFFF_FFFB, 1'b0); // exactly one interval on top
    send_sample(5'd9, 48'd104 + 48'h3_7FFF_FFFB, 1'b0); // backwards by half an interval -> zero busy
    load_config(32'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(5'd20, 48'd7, 1'b0);
    send_sample(5'd20, 48'd7, 1'b0);
  endtask

  // Mostly well-formed per-device sequences sized against the current
  // interval, mixed with restarts, random counters and backward steps.
  task automatic test_random_traffic(int unsigned beats, int unsigned gap_pct,
                                     int unsigned stall_pct, logic [IvW-1:0] iv_cfg,
                                     logic [DecW-1:0] ds, logic [DecW-1:0] dm,
                                     logic [DecW-1:0] dl);
    logic [DevW-1:0] dev;
    logic [CntW-1:0] cnt;
    logic            rs;
    logic [63:0]     iv;
    logic [63:0]     base;
    int unsigned     pick;
    load_config(iv_cfg, ds, dm, dl);
    send_gap_pct  = gap_pct;
    pop_stall_pct = stall_pct;
    iv = (cfg_interval == '0) ? 64'd1 : 64'(cfg_interval);
    repeat (beats) begin
      // a few busy devices get most of the samples so the averages build up
      dev  = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
      base = 64'(last_busy[dev]);
      pick = $urandom_range(99);
      rs   = 1'b0;
      if (pick < 5) begin
        rs  = 1'b1;
        cnt = {16'($urandom), 32'($urandom)};
      end else if (pick < 10) begin
        cnt = {16'($urandom), 32'($urandom)};
      end else if (pick < 18) begin
        cnt = 48'(base - 64'($urandom_range(1000, 1)));
      end else if (pick < 26) begin
        cnt = 48'(base + 3 * iv - 64'd2 + 64'($urandom_range(4)));  // around saturation
      end else begin
        cnt = 48'(base + iv * 64'($urandom_range(100)) / 64'd100 + 64'($urandom_range(3)));
      end
      send_sample(dev, cnt, rs);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_samples();
    test_config_extremes();
    // short interval with random decays; then a random full-width interval
    // with decay extremes; then back to the defaults with no idling at all
    test_random_traffic(310, 26, 56, 32'($urandom_range(5000, 1)), 16'($urandom),
                        16'($urandom), 16'($urandom));
    test_random_traffic(310, 56, 26, 32'($urandom), 16'hFFFF, 16'h0000, 16'($urandom));
    test_random_traffic(330, 0, 0, IntervalRst, DecayShortRst, DecayMediumRst,
                        DecayLongRst);

    wait_all_results();
    // let any stray beat surface before the verdict
    repeat (TailCycles) @(posedge clk_i);
    if (bad_beats == 0) begin
      $display("disk_busy_load_average: match");
    end else begin
      $display("disk_busy_load_average: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dbla_pkg.sv
sv/dbla_ram.sv
sv/dbla_front.sv
sv/dbla_back.sv
sv/disk_busy_load_average.sv
test/tb_top.sv
